// ===== rtl/sdi_pkg.sv =====
// ----------------------------------------------------------------------------
// sdi_pkg
// Shared types and constants of the SD card SPI-mode start-up sequencer.
// ----------------------------------------------------------------------------
package sdi_pkg;

	// Start-up phase, also reported as the status code
	typedef enum logic [3:0] {
		PH_STARTING      = 4'd0,
		PH_RESET         = 4'd1,
		PH_COND          = 4'd2,
		PH_MODERN        = 4'd3,
		PH_OCR           = 4'd4,
		PH_LEGACY        = 4'd5,
		PH_OLDEST        = 4'd6,
		PH_BLOCKSIZE     = 4'd7,
		PH_FINAL         = 4'd8,
		PH_READY         = 4'd9,
		PH_ERR_NO_CARD   = 4'd10,
		PH_ERR_MODERN    = 4'd11,
		PH_ERR_OLDEST    = 4'd12,
		PH_ERR_BLOCKSIZE = 4'd13,
		PH_ERR_INTERNAL  = 4'd14
	} phase_t;

	// Command indexes
	localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
	localparam logic [5:0] CMD_SEND_COND = 6'd8;
	localparam logic [5:0] CMD_APP       = 6'd55;
	localparam logic [5:0] CMD_SD_OP     = 6'd41;
	localparam logic [5:0] CMD_READ_OCR  = 6'd58;
	localparam logic [5:0] CMD_OP_COND   = 6'd1;
	localparam logic [5:0] CMD_BLOCKLEN  = 6'd16;

	// Arguments
	localparam logic [31:0] ARG_NONE      = 32'h0000_0000;
	localparam logic [31:0] ARG_COND      = 32'h0000_01AA;
	localparam logic [31:0] ARG_HCS       = 32'h4000_0000;
	localparam logic [31:0] ARG_BLOCK_512 = 32'h0000_0200;

	// CRC bytes with end bit
	localparam logic [7:0] CRC_GO_IDLE = 8'h95;
	localparam logic [7:0] CRC_COND    = 8'h87;
	localparam logic [7:0] CRC_APP     = 8'h65;
	localparam logic [7:0] CRC_SD_OP   = 8'h77;
	localparam logic [7:0] CRC_NONE    = 8'hFF;

	// R1 codes
	localparam logic [7:0] R1_READY = 8'h00;
	localparam logic [7:0] R1_IDLE  = 8'h01;

	// OCR card capacity status bit
	localparam int OCR_CCS_BIT = 30;

	localparam logic [7:0] RETRY_LIMIT_RST = 8'd250;
	localparam logic [7:0] RETRY_MAX       = 8'hFF;

	typedef struct packed {
		phase_t     phase;
		logic       app_sent;
		logic [7:0] retry;
		logic       clk_fast;
	} seq_state_t;

	typedef struct packed {
		logic        command;
		logic [7:0]  r1;
		logic [31:0] data;
	} in_item_t;

	typedef struct packed {
		logic        issue;
		logic [5:0]  index;
		logic [31:0] argument;
		logic [7:0]  crc;
		logic        wake;
		logic        fast;
		phase_t      status;
	} result_t;

endpackage

// ===== rtl/sdi_in_stage.sv =====
// ----------------------------------------------------------------------------
// sdi_in_stage
// Input register: holds one accepted request until the step logic takes it.
// ----------------------------------------------------------------------------
module sdi_in_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  sdi_pkg::in_item_t item,
	input  logic             advance,
	output logic             valid_s1,
	output sdi_pkg::in_item_t item_s1
);
	import sdi_pkg::*;

	logic load;

	assign in_stall = valid_s1 & ~advance;
	assign load     = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= load | (valid_s1 & ~advance);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item;
		end
	end

endmodule

// ===== rtl/sdi_step.sv =====
// ----------------------------------------------------------------------------
// sdi_step
// One sequencer step: next state and the command to issue next.
// ----------------------------------------------------------------------------
module sdi_step (
	input  sdi_pkg::seq_state_t st,
	input  sdi_pkg::in_item_t   item,
	input  logic [7:0]          retry_limit,
	output sdi_pkg::seq_state_t st_nxt,
	output sdi_pkg::result_t    res
);
	import sdi_pkg::*;

	logic       r1_idle;
	logic       r1_ready;
	logic [7:0] retry_inc;
	logic       wake;

	assign r1_idle   = (item.r1 == R1_IDLE);
	assign r1_ready  = (item.r1 == R1_READY);
	assign retry_inc = (st.retry == RETRY_MAX) ? st.retry : st.retry + 8'd1;

	// state transition
	always_comb begin
		st_nxt = st;
		wake   = 1'b0;
		if (st.phase >= PH_ERR_NO_CARD) begin
			st_nxt.phase = PH_ERR_INTERNAL;
		end else if (!item.command) begin
			case (st.phase)
				PH_STARTING: begin
					wake            = 1'b1;
					st_nxt.clk_fast = 1'b0;
					st_nxt.retry    = '0;
					st_nxt.app_sent = 1'b0;
					st_nxt.phase    = PH_RESET;
				end
				PH_READY: begin
					st_nxt.clk_fast = 1'b0;
					st_nxt.phase    = PH_RESET;
				end
				PH_FINAL: begin
					st_nxt.clk_fast = 1'b1;
					st_nxt.phase    = PH_READY;
				end
				default: ;
			endcase
		end else begin
			case (st.phase)
				PH_RESET: begin
					if (r1_idle) begin
						st_nxt.retry = '0;
						st_nxt.phase = PH_COND;
					end else begin
						st_nxt.retry = retry_inc;
						if (retry_inc > retry_limit) st_nxt.phase = PH_ERR_NO_CARD;
					end
				end
				PH_COND: begin
					st_nxt.app_sent = 1'b0;
					if (r1_idle) begin
						st_nxt.phase = (item.data == ARG_COND) ? PH_MODERN : PH_ERR_MODERN;
					end else begin
						st_nxt.phase = PH_LEGACY;
					end
				end
				PH_MODERN: begin
					if (!st.app_sent) begin
						if (r1_idle) st_nxt.app_sent = 1'b1;
						else st_nxt.phase = PH_ERR_MODERN;
					end else begin
						st_nxt.app_sent = 1'b0;
						if (r1_ready) st_nxt.phase = PH_OCR;
						else if (!r1_idle) st_nxt.phase = PH_ERR_MODERN;
					end
				end
				PH_OCR: begin
					if (r1_ready) begin
						st_nxt.phase = item.data[OCR_CCS_BIT] ? PH_FINAL : PH_BLOCKSIZE;
					end else begin
						st_nxt.phase = PH_ERR_MODERN;
					end
				end
				PH_LEGACY: begin
					if (!st.app_sent) begin
						if (r1_idle) st_nxt.app_sent = 1'b1;
						else st_nxt.phase = PH_OLDEST;
					end else begin
						st_nxt.app_sent = 1'b0;
						if (r1_ready) st_nxt.phase = PH_BLOCKSIZE;
						else if (!r1_idle) st_nxt.phase = PH_OLDEST;
					end
				end
				PH_OLDEST: begin
					if (r1_ready) st_nxt.phase = PH_BLOCKSIZE;
					else if (!r1_idle) st_nxt.phase = PH_ERR_OLDEST;
				end
				PH_BLOCKSIZE: begin
					st_nxt.phase = r1_ready ? PH_FINAL : PH_ERR_BLOCKSIZE;
				end
				default: begin
					st_nxt.phase = PH_ERR_INTERNAL;
				end
			endcase
		end
	end

	// pending command for the new phase
	always_comb begin
		res          = '0;
		res.wake     = wake;
		res.fast     = st_nxt.clk_fast;
		res.status   = st_nxt.phase;
		case (st_nxt.phase)
			PH_RESET: begin
				res.issue = 1'b1;
				res.index = CMD_GO_IDLE;
				res.crc   = CRC_GO_IDLE;
			end
			PH_COND: begin
				res.issue    = 1'b1;
				res.index    = CMD_SEND_COND;
				res.argument = ARG_COND;
				res.crc      = CRC_COND;
			end
			PH_MODERN, PH_LEGACY: begin
				res.issue = 1'b1;
				if (st_nxt.app_sent) begin
					res.index    = CMD_SD_OP;
					res.argument = ARG_HCS;
					res.crc      = CRC_SD_OP;
				end else begin
					res.index = CMD_APP;
					res.crc   = CRC_APP;
				end
			end
			PH_OCR: begin
				res.issue = 1'b1;
				res.index = CMD_READ_OCR;
				res.crc   = CRC_NONE;
			end
			PH_OLDEST: begin
				res.issue = 1'b1;
				res.index = CMD_OP_COND;
				res.crc   = CRC_NONE;
			end
			PH_BLOCKSIZE: begin
				res.issue    = 1'b1;
				res.index    = CMD_BLOCKLEN;
				res.argument = ARG_BLOCK_512;
				res.crc      = CRC_NONE;
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/sd_spi_init_sequencer.sv =====
// ----------------------------------------------------------------------------
// sd_spi_init_sequencer
// SD card SPI-mode start-up sequencer: CMD0, CMD8, CMD55/ACMD41, CMD58,
// CMD1 and CMD16, one card exchange per request.
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  -------   ------------------   -------------------------------------------
//  in        in_valid/in_stall    command, response_r1, response_data
//  out       out_valid/out_stall  issue_command, command_index,
//                                 command_argument, command_crc,
//                                 send_wake_clocks, fast_clock, status
//  cfg       cfg_write_en         cfg_write_data (reset_retry_limit)
//
//  One request per cycle sustained while the result side does not stall; a
//  result passes through the input register, then the result register.
//  The step logic sits between the two registers and updates the sequencer
//  state in the same edge that loads the result, so back-to-back requests
//  always see the state left by the one before.
//  Reset: phase starting, counters clear, retry limit 250.
//  A stalled result register holds the input register; the input stalls only
//  when both are full and the result is stalled.
// ----------------------------------------------------------------------------
module sd_spi_init_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_write_en,
	input  logic [7:0]  cfg_write_data,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [7:0]  response_r1,
	input  logic [31:0] response_data,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        issue_command,
	output logic [5:0]  command_index,
	output logic [31:0] command_argument,
	output logic [7:0]  command_crc,
	output logic        send_wake_clocks,
	output logic        fast_clock,
	output logic [3:0]  status
);
	import sdi_pkg::*;

	logic [7:0] limit_q;

	in_item_t   item;
	in_item_t   item_s1;
	logic       valid_s1;
	logic       advance;

	seq_state_t state_q;
	seq_state_t state_nxt;
	result_t    res;
	result_t    result_s2;
	logic       valid_s2;

	// retry limit register: to be written only while idle, which the block does not enforce
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= RETRY_LIMIT_RST;
		end else if (cfg_write_en) begin
			limit_q <= cfg_write_data;
		end
	end

	// a stored request moves on when the result register is free or draining
	assign advance = valid_s1 & (~valid_s2 | ~out_stall);

	assign item.command = command;
	assign item.r1      = response_r1;
	assign item.data    = response_data;

	sdi_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.item     (item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	sdi_step u_step (
		.st          (state_q),
		.item        (item_s1),
		.retry_limit (limit_q),
		.st_nxt      (state_nxt),
		.res         (res)
	);

	// sequencer state: updated once per request, with its result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase    <= PH_STARTING;
			state_q.app_sent <= 1'b0;
			state_q.retry    <= '0;
			state_q.clk_fast <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= advance | (valid_s2 & out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= res;
		end
	end

	assign out_valid        = valid_s2;
	assign issue_command    = result_s2.issue;
	assign command_index    = result_s2.index;
	assign command_argument = result_s2.argument;
	assign command_crc      = result_s2.crc;
	assign send_wake_clocks = result_s2.wake;
	assign fast_clock       = result_s2.fast;
	assign status           = result_s2.status;

`ifndef SYNTH
	// internal error is a sink, only reset leaves it
	a_err_sink: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == PH_ERR_INTERNAL) |=> (state_q.phase == PH_ERR_INTERNAL))
		else $error("sequencer left internal error phase");

	// no command means empty command fields
	a_no_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !issue_command) |->
		(command_index == CMD_GO_IDLE && command_argument == ARG_NONE &&
		 command_crc == 8'h00))
		else $error("command fields set without a command");

	// wake clocks only lead into CMD0 at slow speed
	a_wake: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && send_wake_clocks) |->
		(status == PH_RESET && !fast_clock && command_index == CMD_GO_IDLE))
		else $error("wake clocks outside reset phase");

	// retry count only survives in the CMD0 phase or its error exits
	a_retry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.retry != 8'd0) |->
		(state_q.phase == PH_RESET || state_q.phase == PH_ERR_NO_CARD ||
		 state_q.phase == PH_ERR_INTERNAL))
		else $error("retry count left over");

	// fast clock only once the card is ready
	a_fast: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.clk_fast |->
		(state_q.phase == PH_READY || state_q.phase == PH_ERR_INTERNAL))
		else $error("fast clock before card ready");

	// a request taken while the result register is full and stalled waits
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && out_stall) |=> (valid_s1 && $stable(state_q)))
		else $error("request lost under output stall");
`endif

endmodule

// ===== bench/sd_spi_init_sequencer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sd_spi_init_sequencer_tb
// Self-checking bench for the SD card SPI-mode start-up sequencer. A copy of
// the phase walk predicts every result. Random card answers mostly follow the
// legal start-up paths under several retry limits, and one fatal fault ends
// the run because only reset can clear an error phase.
// ----------------------------------------------------------------------------

module sd_spi_init_sequencer_tb;
	import sdi_pkg::*;

	// Shadow of the sequencer state plus the results still owed by the block
	class sd_init_scoreboard;
		phase_t     phase          = PH_STARTING;
		logic       app_sent       = 1'b0;
		logic [7:0] retry          = 8'd0;
		logic       clk_fast       = 1'b0;
		logic [7:0] limit          = RETRY_LIMIT_RST;
		result_t    expected_results[$];
		int         mismatch_count = 0;

		// Step the shadow state for one accepted request and queue its result
		function void note_request(in_item_t req);
			result_t r;
			logic    wake;
			wake = 1'b0;
			r    = '0;
			if (phase >= PH_ERR_NO_CARD) begin
				phase = PH_ERR_INTERNAL;
			end else if (!req.command) begin
				case (phase)
				PH_STARTING: begin
					wake     = 1'b1;
					clk_fast = 1'b0;
					retry    = 8'd0;
					app_sent = 1'b0;
					phase    = PH_RESET;
				end
				PH_READY: begin
					clk_fast = 1'b0;
					phase    = PH_RESET;
				end
				PH_FINAL: begin
					clk_fast = 1'b1;
					phase    = PH_READY;
				end
				default: ;
				endcase
			end else begin
				case (phase)
				PH_RESET: begin
					if (req.r1 == R1_IDLE) begin
						retry = 8'd0;
						phase = PH_COND;
					end else begin
						if (retry < RETRY_MAX)
							retry = retry + 8'd1;
						if (retry > limit)
							phase = PH_ERR_NO_CARD;
					end
				end
				PH_COND: begin
					app_sent = 1'b0;
					if (req.r1 == R1_IDLE)
						phase = (req.data == ARG_COND) ? PH_MODERN : PH_ERR_MODERN;
					else
						phase = PH_LEGACY;
				end
				PH_MODERN: begin
					if (!app_sent) begin
						if (req.r1 == R1_IDLE)
							app_sent = 1'b1;
						else
							phase = PH_ERR_MODERN;
					end else begin
						app_sent = 1'b0;
						if (req.r1 == R1_READY)
							phase = PH_OCR;
						else if (req.r1 != R1_IDLE)
							phase = PH_ERR_MODERN;
					end
				end
				PH_OCR: begin
					if (req.r1 == R1_READY)
						phase = req.data[OCR_CCS_BIT] ? PH_FINAL : PH_BLOCKSIZE;
					else
						phase = PH_ERR_MODERN;
				end
				PH_LEGACY: begin
					if (!app_sent) begin
						if (req.r1 == R1_IDLE)
							app_sent = 1'b1;
						else
							phase = PH_OLDEST;
					end else begin
						app_sent = 1'b0;
						if (req.r1 == R1_READY)
							phase = PH_BLOCKSIZE;
						else if (req.r1 != R1_IDLE)
							phase = PH_OLDEST;
					end
				end
				PH_OLDEST: begin
					if (req.r1 == R1_READY)
						phase = PH_BLOCKSIZE;
					else if (req.r1 != R1_IDLE)
						phase = PH_ERR_OLDEST;
				end
				PH_BLOCKSIZE: begin
					phase = (req.r1 == R1_READY) ? PH_FINAL : PH_ERR_BLOCKSIZE;
				end
				default: begin
					phase = PH_ERR_INTERNAL;
				end
				endcase
			end

			// command the card is waiting for; nothing outside reset..blocksize
			r.issue = (phase >= PH_RESET) && (phase <= PH_BLOCKSIZE);
			case (phase)
			PH_RESET: begin
				r.index = CMD_GO_IDLE;
				r.crc   = CRC_GO_IDLE;
			end
			PH_COND: begin
				r.index    = CMD_SEND_COND;
				r.argument = ARG_COND;
				r.crc      = CRC_COND;
			end
			PH_MODERN, PH_LEGACY: begin
				if (app_sent) begin
					r.index    = CMD_SD_OP;
					r.argument = ARG_HCS;
					r.crc      = CRC_SD_OP;
				end else begin
					r.index = CMD_APP;
					r.crc   = CRC_APP;
				end
			end
			PH_OCR: begin
				r.index = CMD_READ_OCR;
				r.crc   = CRC_NONE;
			end
			PH_OLDEST: begin
				r.index = CMD_OP_COND;
				r.crc   = CRC_NONE;
			end
			PH_BLOCKSIZE: begin
				r.index    = CMD_BLOCKLEN;
				r.argument = ARG_BLOCK_512;
				r.crc      = CRC_NONE;
			end
			default: ;
			endcase
			r.wake   = wake;
			r.fast   = clk_fast;
			r.status = phase;
			expected_results.push_back(r);
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				mismatch_count++;
				$display("%0t: %s expected %0h, got %0h", $time, field, want, got);
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_results.size() == 0) begin
				mismatch_count++;
				$display("%0t: result %h with no request outstanding", $time, got);
				return;
			end
			want = expected_results.pop_front();
			compare_field("issue_command", 32'(want.issue), 32'(got.issue));
			compare_field("command_index", 32'(want.index), 32'(got.index));
			compare_field("command_argument", want.argument, got.argument);
			compare_field("command_crc", 32'(want.crc), 32'(got.crc));
			compare_field("send_wake_clocks", 32'(want.wake), 32'(got.wake));
			compare_field("fast_clock", 32'(want.fast), 32'(got.fast));
			compare_field("status", 32'(want.status), 32'(got.status));
		endfunction
	endclass

	logic        clk;
	logic        arst_n         = 1'b0;
	logic        cfg_write_en   = 1'b0;
	logic [7:0]  cfg_write_data = 8'd0;
	logic        in_valid       = 1'b0;
	logic        in_stall;
	logic        command        = 1'b0;
	logic [7:0]  response_r1    = 8'd0;
	logic [31:0] response_data  = 32'd0;
	logic        out_valid;
	logic        out_stall      = 1'b0;
	logic        issue_command;
	logic [5:0]  command_index;
	logic [31:0] command_argument;
	logic [7:0]  command_crc;
	logic        send_wake_clocks;
	logic        fast_clock;
	logic [3:0]  status;

	// while set, neither side inserts gaps or stalls
	bit quiet = 1'b0;
	// forced CMD0 misses still to come, used to drive the retry count to saturation
	int fail_burst = 0;

	sd_init_scoreboard sb = new();

	sd_spi_init_sequencer i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write_en     (cfg_write_en),
		.cfg_write_data   (cfg_write_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.command          (command),
		.response_r1      (response_r1),
		.response_data    (response_data),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.issue_command    (issue_command),
		.command_index    (command_index),
		.command_argument (command_argument),
		.command_crc      (command_crc),
		.send_wake_clocks (send_wake_clocks),
		.fast_clock       (fast_clock),
		.status           (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side: random back-pressure, stalling with about 7 percent chance.
	always @(posedge clk) begin
		out_stall <= !quiet && ($urandom_range(0, 99) < 7);
	end

	// Values read straight after the edge are the ones the block saw at it.
	always @(posedge clk) begin
		result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.issue    = issue_command;
			got.index    = command_index;
			got.argument = command_argument;
			got.crc      = command_crc;
			got.wake     = send_wake_clocks;
			got.fast     = fast_clock;
			got.status   = phase_t'(status);
			sb.check_result(got);
		end
	end

	// Offer one request, with random gaps ahead of it, and hold it until taken.
	task automatic send_request(logic cmd, logic [7:0] r1, logic [31:0] data);
		in_item_t req;
		req.command = cmd;
		req.r1      = r1;
		req.data    = data;
		while (!quiet && $urandom_range(0, 99) < 7) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		command       <= cmd;
		response_r1   <= r1;
		response_data <= data;
		do begin
			@(posedge clk);
		end while (in_stall);
		sb.note_request(req);
	endtask

	// Limit changes only once the block has handed back every result.
	task automatic write_retry_limit(logic [7:0] value);
		in_valid <= 1'b0;
		while (sb.expected_results.size() != 0)
			@(posedge clk);
		cfg_write_en   <= 1'b1;
		cfg_write_data <= value;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		sb.limit = value;
	endtask

	function automatic logic [7:0] any_r1_but(logic [7:0] a, logic [7:0] b);
		logic [7:0] v;
		do begin
			v = 8'($urandom);
		end while (v == a || v == b);
		return v;
	endfunction

	// A card answer that keeps the sequence alive, drawn from the shadow phase.
	// CMD0 misses are only offered while they cannot exhaust the retry limit.
	function automatic in_item_t next_good_request();
		in_item_t req;
		logic     may_fail;
		int       pick;
		req.command = 1'b1;
		req.r1      = 8'($urandom);
		req.data    = $urandom;
		may_fail    = (sb.limit == RETRY_MAX) || (sb.retry < sb.limit);
		pick        = $urandom_range(0, 99);
		// stray advance while a response is pending: command named again
		if (sb.phase >= PH_RESET && sb.phase <= PH_BLOCKSIZE && pick < 10) begin
			req.command = 1'b0;
			return req;
		end
		pick = $urandom_range(0, 99);
		case (sb.phase)
		PH_RESET: begin
			if (may_fail && (fail_burst > 0 || pick < 25)) begin
				req.r1 = any_r1_but(R1_IDLE, R1_IDLE);
				if (fail_burst > 0)
					fail_burst--;
			end else begin
				req.r1 = R1_IDLE;
			end
		end
		PH_COND: begin
			// a good echo opens the modern path, a non-idle answer the legacy one
			if (pick < 55) begin
				req.r1   = R1_IDLE;
				req.data = ARG_COND;
			end else begin
				req.r1 = any_r1_but(R1_IDLE, R1_IDLE);
			end
		end
		PH_MODERN: begin
			req.r1 = (!sb.app_sent || pick < 40) ? R1_IDLE : R1_READY;
		end
		PH_OCR, PH_BLOCKSIZE: begin
			req.r1 = R1_READY;
		end
		PH_LEGACY: begin
			// a legacy refusal falls back to CMD1, which is still a live path
			if (!sb.app_sent)
				req.r1 = (pick < 80) ? R1_IDLE : any_r1_but(R1_IDLE, R1_IDLE);
			else if (pick < 30)
				req.r1 = R1_IDLE;
			else if (pick < 80)
				req.r1 = R1_READY;
			else
				req.r1 = any_r1_but(R1_READY, R1_IDLE);
		end
		PH_OLDEST: begin
			req.r1 = (pick < 40) ? R1_IDLE : R1_READY;
		end
		default: begin
			// starting, final and ready move on by an advance only
			req.command = 1'b0;
		end
		endcase
		return req;
	endfunction

	// A card answer that drives the current phase into its error phase.
	function automatic in_item_t next_broken_request();
		in_item_t req;
		req.command = 1'b1;
		req.r1      = 8'($urandom);
		req.data    = $urandom;
		case (sb.phase)
		PH_RESET: begin
			req.r1 = any_r1_but(R1_IDLE, R1_IDLE);
		end
		PH_COND: begin
			req.r1 = R1_IDLE;
			while (req.data == ARG_COND)
				req.data = $urandom;
		end
		PH_MODERN: begin
			req.r1 = sb.app_sent ? any_r1_but(R1_READY, R1_IDLE)
			                     : any_r1_but(R1_IDLE, R1_IDLE);
		end
		PH_OCR, PH_BLOCKSIZE: begin
			req.r1 = any_r1_but(R1_READY, R1_READY);
		end
		PH_OLDEST: begin
			req.r1 = any_r1_but(R1_READY, R1_IDLE);
		end
		default: ;	// a response in final or ready is the fault itself
		endcase
		return req;
	endfunction

	initial begin
		in_item_t   req;
		phase_t     fault_targets[8];
		phase_t     fault_phase;
		logic [7:0] new_limit;
		int         guard;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed walk at the reset limit.
		// Wake-up, CMD0 misses around a stray advance, then legacy falling to CMD1.
		send_request(1'b0, 8'h00, 32'h0000_0000);
		send_request(1'b1, 8'hFF, 32'hFFFF_FFFF);
		send_request(1'b0, 8'hFF, 32'hFFFF_FFFF);
		send_request(1'b1, R1_READY, 32'h0000_0000);
		send_request(1'b1, R1_IDLE, 32'h0000_0000);
		send_request(1'b1, 8'h05, ARG_COND);		// illegal command: legacy card
		send_request(1'b1, R1_IDLE, $urandom);
		send_request(1'b1, R1_IDLE, $urandom);		// ACMD41 still idle
		send_request(1'b1, R1_IDLE, $urandom);
		send_request(1'b1, 8'h04, $urandom);		// ACMD41 refused: oldest path
		send_request(1'b1, R1_IDLE, 32'h0000_0000);
		send_request(1'b1, R1_READY, 32'hFFFF_FFFF);
		send_request(1'b0, 8'h00, 32'h0000_0000);
		send_request(1'b1, R1_READY, $urandom);		// CMD16 done
		send_request(1'b0, 8'h00, 32'h0000_0000);	// fast clock on
		send_request(1'b0, 8'h00, 32'h0000_0000);	// back to CMD0, slow, no wake
		// modern card with the capacity bit set skips CMD16
		send_request(1'b1, R1_IDLE, 32'h0000_0000);
		send_request(1'b1, R1_IDLE, ARG_COND);
		send_request(1'b1, R1_IDLE, $urandom);
		send_request(1'b1, R1_IDLE, $urandom);
		send_request(1'b1, R1_IDLE, $urandom);
		send_request(1'b1, R1_READY, $urandom);
		send_request(1'b1, R1_READY, ARG_HCS);
		send_request(1'b0, 8'h00, 32'h0000_0000);
		send_request(1'b0, 8'h00, 32'h0000_0000);

		// Random walks under a range of retry limits. The saturating limit gets
		// a long run of CMD0 misses with no idling on either side.
		for (int p = 0; p < 5; p++) begin
			case (p)
			0:       new_limit = 8'd0;
			1:       new_limit = RETRY_MAX;
			2:       new_limit = 8'($urandom_range(1, 254));
			3:       new_limit = 8'd1;
			default: new_limit = 8'($urandom_range(0, 7));
			endcase
			write_retry_limit(new_limit);
			quiet      = (p == 1);
			fail_burst = (p == 1) ? 300 : 0;
			repeat ((p == 1) ? 360 : 80) begin
				req = next_good_request();
				send_request(req.command, req.r1, req.data);
			end
		end
		quiet = 1'b0;

		// One fatal fault in a phase picked at random, then noise on the
		// internal error phase, which only reset can leave.
		fault_targets = '{PH_RESET, PH_COND, PH_MODERN, PH_OCR,
		                  PH_OLDEST, PH_BLOCKSIZE, PH_FINAL, PH_READY};
		fault_phase   = fault_targets[$urandom_range(0, 7)];
		guard         = 0;
		while (sb.phase < PH_ERR_NO_CARD && guard < 1500) begin
			req = (sb.phase == fault_phase) ? next_broken_request() : next_good_request();
			send_request(req.command, req.r1, req.data);
			guard++;
		end
		repeat (8) begin
			send_request(1'($urandom), 8'($urandom), $urandom);
		end

		in_valid <= 1'b0;
		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog: reports mismatches and ends the run if the test hangs.
	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/sdi_pkg.sv
rtl/sdi_in_stage.sv
rtl/sdi_step.sv
rtl/sd_spi_init_sequencer.sv
bench/sd_spi_init_sequencer_tb.sv
